// File: hw/rtl/yrgb_pkg.sv
// Shared types, constants and helpers for the YUYV to RGB/BGR/grey converter.
`timescale 1ns / 1ps

package yrgb_pkg;

	// Output format codes held in the mode register.
	localparam logic [1:0] MODE_RGB  = 2'd0;
	localparam logic [1:0] MODE_BGR  = 2'd1;
	localparam logic [1:0] MODE_GREY = 2'd2;

	// Chroma coefficients, eight fractional bits.
	localparam logic signed [16:0] K_CB   = 17'sd454;
	localparam logic signed [16:0] K_CR   = 17'sd359;
	localparam logic signed [16:0] K_CG_U = 17'sd88;
	localparam logic signed [16:0] K_CG_V = 17'sd183;

	// Upper end of a component.
	localparam logic [7:0] COMP_MAX = 8'd255;

	// One output pixel, three components in output order.
	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} pixel_t;

	// Clamp a signed sum of luma and chroma term to 0..255.
	function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
		logic [7:0] r;
		if (v[10]) begin
			r = 8'd0;
		end else if (v[9:8] != 2'b00) begin
			r = COMP_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/yrgb_convert.sv
// Combinational color conversion of one YUYV macropixel into two output pixels.
`timescale 1ns / 1ps

module yrgb_convert (
	input  logic [1:0]      mode,
	input  logic [7:0]      luma_a,
	input  logic [7:0]      chroma_b,
	input  logic [7:0]      luma_b,
	input  logic [7:0]      chroma_r,
	output yrgb_pkg::pixel_t pix0,
	output yrgb_pkg::pixel_t pix1
);
	import yrgb_pkg::*;

	logic signed [7:0]  u_off;
	logic signed [7:0]  v_off;
	logic signed [16:0] u_x;
	logic signed [16:0] v_x;
	logic signed [16:0] prod_cb;
	logic signed [16:0] prod_cr;
	logic signed [16:0] sum_cg;
	logic signed [10:0] cb;
	logic signed [10:0] cr;
	logic signed [10:0] cg;
	logic signed [10:0] y0_x;
	logic signed [10:0] y1_x;

	// Removing the 128 offset is an inversion of the top bit.
	assign u_off = {~chroma_b[7], chroma_b[6:0]};
	assign v_off = {~chroma_r[7], chroma_r[6:0]};
	assign u_x   = 17'(u_off);
	assign v_x   = 17'(v_off);

	// Chroma products; all fit in 17 signed bits.
	assign prod_cb = u_x * K_CB;
	assign prod_cr = v_x * K_CR;
	assign sum_cg  = u_x * K_CG_U + v_x * K_CG_V;

	// Dropping the low eight bits of a two's complement value floors it.
	assign cb = 11'($signed(prod_cb[16:8]));
	assign cr = 11'($signed(prod_cr[16:8]));
	assign cg = 11'($signed(sum_cg[16:8]));

	assign y0_x = $signed({3'b000, luma_a});
	assign y1_x = $signed({3'b000, luma_b});

	// Component order per mode; the top mode bit selects grey.
	function automatic pixel_t build_pixel(input logic [1:0] m,
	                                       input logic signed [10:0] y,
	                                       input logic [7:0] y_raw,
	                                       input logic signed [10:0] t_cr,
	                                       input logic signed [10:0] t_cg,
	                                       input logic signed [10:0] t_cb);
		pixel_t     p;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = clamp_byte(y + t_cr);
		g = clamp_byte(y - t_cg);
		b = clamp_byte(y + t_cb);
		case (m)
			MODE_RGB: begin
				p = '{c0: r, c1: g, c2: b};
			end
			MODE_BGR: begin
				p = '{c0: b, c1: g, c2: r};
			end
			default: begin
				p = '{c0: y_raw, c1: 8'd0, c2: 8'd0};
			end
		endcase
		return p;
	endfunction

	assign pix0 = build_pixel(mode, y0_x, luma_a, cr, cg, cb);
	assign pix1 = build_pixel(mode, y1_x, luma_b, cr, cg, cb);

endmodule

// File: hw/rtl/yuyv_to_rgb_bgr_gray.sv
// Top level: YUYV macropixel to two RGB, BGR or grey pixels, two-stage pipeline.
//
// Input channel: in_valid with luma_first, chroma_blue, luma_second, chroma_red
// and frame_end_in; a beat is taken at a clock edge where in_valid is high and
// in_stall is low. Output channel: out_valid with p0_comp*, p1_comp* and
// frame_end_out; a beat leaves where out_valid is high and out_stall is low.
// Configuration: cfg_valid/cfg_ready with cfg_data[1:0] sets the output mode
// (RGB, BGR, grey; the code 3 acts as grey). cfg_ready is always high; the
// mode is meant to change only while no beat is in flight.
// An accepted input beat passes through the input register, then the
// conversion logic into the output register, and leaves as its output beat.
// Throughput is one macropixel per cycle while the receiver does not stall,
// set by the single pass of the conversion logic between the two registers.
// When the receiver stalls, the output register holds its beat and the input
// register takes one more beat if it is empty; after that in_stall rises until
// the output drains. Reset empties both stages and sets the mode to RGB.
`timescale 1ns / 1ps

module yuyv_to_rgb_bgr_gray (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] luma_first,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] luma_second,
	input  logic [7:0] chroma_red,
	input  logic       frame_end_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] p0_comp0,
	output logic [7:0] p0_comp1,
	output logic [7:0] p0_comp2,
	output logic [7:0] p1_comp0,
	output logic [7:0] p1_comp1,
	output logic [7:0] p1_comp2,
	output logic       frame_end_out
);
	import yrgb_pkg::*;

	logic [1:0] mode_q;
	logic       valid_s1;
	logic       valid_s2;
	logic [7:0] luma_a_s1;
	logic [7:0] chroma_b_s1;
	logic [7:0] luma_b_s1;
	logic [7:0] chroma_r_s1;
	logic       frame_end_s1;
	pixel_t     pix0_s2;
	pixel_t     pix1_s2;
	logic       frame_end_s2;
	pixel_t     pix0_c;
	pixel_t     pix1_c;
	logic       adv_s2;
	logic       take_in;

	// Mode register write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RGB;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// Pipeline flow control.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (take_in) begin
			luma_a_s1    <= luma_first;
			chroma_b_s1  <= chroma_blue;
			luma_b_s1    <= luma_second;
			chroma_r_s1  <= chroma_red;
			frame_end_s1 <= frame_end_in;
		end
	end

	// Conversion logic.
	yrgb_convert u_convert (
		.mode     (mode_q),
		.luma_a   (luma_a_s1),
		.chroma_b (chroma_b_s1),
		.luma_b   (luma_b_s1),
		.chroma_r (chroma_r_s1),
		.pix0     (pix0_c),
		.pix1     (pix1_c)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pix0_s2      <= pix0_c;
			pix1_s2      <= pix1_c;
			frame_end_s2 <= frame_end_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign p0_comp0      = pix0_s2.c0;
	assign p0_comp1      = pix0_s2.c1;
	assign p0_comp2      = pix0_s2.c2;
	assign p1_comp0      = pix1_s2.c0;
	assign p1_comp1      = pix1_s2.c1;
	assign p1_comp2      = pix1_s2.c2;
	assign frame_end_out = frame_end_s2;

endmodule
